// ===== src/round_robin_thread_scheduler_macros.svh =====
// Assertion macros used by the scheduler top level.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rrts_pkg.sv =====
// Shared types and constants of the round-robin thread scheduler.
package rrts_pkg;

  localparam int MAX_THREADS_DEF = 16;
  localparam int FUNC_W = 3;
  localparam int ID_W   = 6;
  localparam int LEN_W  = 16;
  localparam int OC_W   = 3;
  localparam int CNT_W  = 32;

  // Event codes carried by an input item; the last code does nothing.
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_SPAWN  = 3'd1,
    FN_TERM   = 3'd2,
    FN_BLOCK  = 3'd3,
    FN_RESUME = 3'd4,
    FN_SLEEP  = 3'd5,
    FN_QUERY  = 3'd6,
    FN_UNUSED = 3'd7
  } func_t;

  // Outcome codes returned with each result item.
  typedef enum logic [OC_W-1:0] {
    OC_OK         = 3'd0,
    OC_NO_THREAD  = 3'd1,
    OC_TABLE_FULL = 3'd2,
    OC_MAIN_BLOCK = 3'd3,
    OC_MAIN_SLEEP = 3'd4,
    OC_BAD_LEN    = 3'd5,
    OC_MAIN_TERM  = 3'd6
  } outcome_t;

  // Per-thread status.
  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } status_t;

  // One thread table entry.
  typedef struct packed {
    status_t            status;
    logic [CNT_W-1:0]   quanta;
    logic [CNT_W-1:0]   wake;
    logic               hold;
  } thread_ent_t;

  // Control of the thread ring: rotate one place, writing the head entry back at the tail.
  typedef struct packed {
    logic        shift;
    thread_ent_t wr;
  } ring_ctrl_t;

  // Control of the ready queue.
  typedef struct packed {
    logic            deq;
    logic            enq;
    logic [ID_W-1:0] val;
  } q_ctrl_t;

endpackage

// ===== src/rrts_thread_cell.sv =====
// One cell of the thread ring: holds a single thread table entry.
module rrts_thread_cell #(
  parameter bit MAIN = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  rrts_pkg::thread_ent_t d,
  output rrts_pkg::thread_ent_t q
);
  import rrts_pkg::*;

  thread_ent_t ent_r;

  // Take the neighbor's entry on a shift; reset puts the main thread in cell zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.status <= MAIN ? ST_RUNNING : ST_UNUSED;
      ent_r.quanta <= MAIN ? CNT_W'(1) : '0;
      ent_r.wake   <= '0;
      ent_r.hold   <= 1'b0;
    end else if (shift) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule

// ===== src/rrts_thread_ring.sv =====
// Ring of thread cells; the head cell is visited once per full rotation.
module rrts_thread_ring #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrts_pkg::ring_ctrl_t ctrl,
  output rrts_pkg::thread_ent_t head
);
  import rrts_pkg::*;

  thread_ent_t q [MAX_THREADS];
  thread_ent_t d [MAX_THREADS];

  // Each cell takes its upper neighbor; the last cell takes the updated head.
  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    if (i == MAX_THREADS - 1) begin : g_tail
      assign d[i] = ctrl.wr;
    end else begin : g_body
      assign d[i] = q[i+1];
    end
    rrts_thread_cell #(.MAIN(i == 0)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ctrl.shift),
      .d     (d[i]),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule

// ===== src/rrts_ready_queue.sv =====
// Ready queue built as a shift chain: dequeue shifts toward the head, enqueue fills the tail.
module rrts_ready_queue #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
  parameter int TW = $clog2(MAX_THREADS),
  parameter int LW = $clog2(MAX_THREADS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rrts_pkg::q_ctrl_t ctrl,
  output logic [TW-1:0]     head,
  output logic [LW-1:0]     len
);
  import rrts_pkg::*;

  logic [TW-1:0] ent_r [MAX_THREADS];
  logic [LW-1:0] len_r;
  logic [LW-1:0] len_nxt;
  logic [LW-1:0] base;
  logic          do_deq;
  logic          do_enq;

  // An enqueue into a full queue is dropped.
  always_comb begin
    do_deq  = ctrl.deq && (len_r != '0);
    base    = len_r - LW'(do_deq);
    do_enq  = ctrl.enq && (base < LW'(MAX_THREADS));
    len_nxt = base + LW'(do_enq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // Entry cells; an enqueue at the new tail wins over the shift.
  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_ent
    if (i == MAX_THREADS - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (do_enq && (base == LW'(i))) begin
          ent_r[i] <= ctrl.val[TW-1:0];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (do_enq && (base == LW'(i))) begin
          ent_r[i] <= ctrl.val[TW-1:0];
        end else if (do_deq) begin
          ent_r[i] <= ent_r[i+1];
        end
      end
    end
  end

  assign head = ent_r[0];
  assign len  = len_r;

endmodule

// ===== src/round_robin_thread_scheduler.sv =====
// Top level of the round-robin thread scheduler: sequencer over the thread ring and ready queue.
//
// Usage: drive in_func, in_thread_id and in_sleep_length and raise start while busy is low;
// the item is taken at that clock edge and busy rises on the next cycle. The result appears
// on the out_ ports for exactly one cycle, marked by out_valid, after which busy falls. The
// receiver cannot hold results off; there is no output stall.
// Passes: the thread table is a ring of MAX_THREADS cells that rotates one place per cycle
// during a table pass, and every table operation is one full rotation. An item takes one
// table pass, then a rotation of the ready queue when a removal is needed, then, when it
// reschedules, a wakeup sweep, requeue, pop, and the sweep that marks the new running
// thread. Items are processed one at a time.
// Reset (synchronous, active low): thread 0 runs with one quantum, the other slots are
// unused, the ready queue is empty and the total quantum count is one. No clearing pass.
`include "round_robin_thread_scheduler_macros.svh"

module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [rrts_pkg::FUNC_W-1:0] in_func,
  input  logic [rrts_pkg::ID_W-1:0]   in_thread_id,
  input  logic [rrts_pkg::LEN_W-1:0]  in_sleep_length,
  output logic                       out_valid,
  output logic [rrts_pkg::OC_W-1:0]   out_outcome,
  output logic [rrts_pkg::CNT_W-1:0]  out_answer,
  output logic [rrts_pkg::ID_W-1:0]   out_running_now,
  output logic [rrts_pkg::CNT_W-1:0]  out_total_now,
  output logic                       out_switched
);
  import rrts_pkg::*;

  localparam int TW = $clog2(MAX_THREADS);
  localparam int LW = $clog2(MAX_THREADS + 1);
  localparam logic [TW-1:0] K_LAST = TW'(MAX_THREADS - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_OPS  = 8'b0000_0010,
    S_RMV  = 8'b0000_0100,
    S_WAKE = 8'b0000_1000,
    S_REQ  = 8'b0001_0000,
    S_POP  = 8'b0010_0000,
    S_RUN  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TW-1:0]     k_r, k_nxt;
  func_t             func_r, func_nxt;
  logic [ID_W-1:0]   tid_r, tid_nxt;
  logic [LEN_W-1:0]  slen_r, slen_nxt;
  outcome_t          outcome_r, outcome_nxt;
  logic [CNT_W-1:0]  answer_r, answer_nxt;
  logic              sw_r, sw_nxt;
  logic              rm_r, rm_nxt;
  logic              found_r, found_nxt;
  logic              cur_req_r, cur_req_nxt;
  logic [TW-1:0]     nxt_id_r, nxt_id_nxt;
  logic [LW-1:0]     rm_len_r, rm_len_nxt;
  logic [TW-1:0]     running_r, running_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;

  ring_ctrl_t        ring_ctrl;
  thread_ent_t       head;
  q_ctrl_t           q_ctrl;
  logic [TW-1:0]     q_head;
  logic [LW-1:0]     q_len;

  logic              k_last;
  logic              tid_hit;
  logic              k_is_run;
  logic              exists;
  logic [CNT_W-1:0]  upcoming;

  rrts_thread_ring #(.MAX_THREADS(MAX_THREADS)) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ring_ctrl),
    .head  (head)
  );

  rrts_ready_queue #(.MAX_THREADS(MAX_THREADS), .TW(TW), .LW(LW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (q_ctrl),
    .head  (q_head),
    .len   (q_len)
  );

  // Compare helpers for the entry at the ring head.
  assign k_last   = (k_r == K_LAST);
  assign tid_hit  = (ID_W'(k_r) == tid_r);
  assign k_is_run = (k_r == running_r);
  assign exists   = (head.status != ST_UNUSED);
  assign upcoming = total_r + CNT_W'(1);

  // Sequencer: one ring rotation per table pass.
  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    func_nxt    = func_r;
    tid_nxt     = tid_r;
    slen_nxt    = slen_r;
    outcome_nxt = outcome_r;
    answer_nxt  = answer_r;
    sw_nxt      = sw_r;
    rm_nxt      = rm_r;
    found_nxt   = found_r;
    cur_req_nxt = cur_req_r;
    nxt_id_nxt  = nxt_id_r;
    rm_len_nxt  = rm_len_r;
    running_nxt = running_r;
    total_nxt   = total_r;
    ring_ctrl.shift = 1'b0;
    ring_ctrl.wr    = head;
    q_ctrl.deq  = 1'b0;
    q_ctrl.enq  = 1'b0;
    q_ctrl.val  = ID_W'(k_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt    = func_t'(in_func);
          tid_nxt     = in_thread_id;
          slen_nxt    = in_sleep_length;
          answer_nxt  = '0;
          sw_nxt      = 1'b0;
          rm_nxt      = 1'b0;
          found_nxt   = 1'b0;
          cur_req_nxt = 1'b0;
          k_nxt       = '0;
          outcome_nxt = OC_OK;
          state_nxt   = S_OPS;
          case (func_t'(in_func))
            FN_TICK:  sw_nxt = 1'b1;
            FN_SPAWN: outcome_nxt = OC_TABLE_FULL;
            FN_TERM, FN_BLOCK, FN_RESUME, FN_QUERY: outcome_nxt = OC_NO_THREAD;
            FN_SLEEP: begin
              if (running_r == '0) begin
                outcome_nxt = OC_MAIN_SLEEP;
              end else if (in_sleep_length == '0) begin
                outcome_nxt = OC_BAD_LEN;
              end else begin
                sw_nxt = 1'b1;
              end
            end
            default: outcome_nxt = OC_OK;
          endcase
        end
      end

      // Apply the event to the target entry as it passes the head.
      S_OPS: begin
        ring_ctrl.shift = 1'b1;
        case (func_r)
          FN_SPAWN: begin
            if ((k_r != '0) && !found_r && !exists) begin
              found_nxt          = 1'b1;
              ring_ctrl.wr.status = ST_READY;
              ring_ctrl.wr.quanta = '0;
              ring_ctrl.wr.wake   = '0;
              ring_ctrl.wr.hold   = 1'b0;
              q_ctrl.enq         = 1'b1;
              outcome_nxt        = OC_OK;
              answer_nxt         = CNT_W'(k_r);
            end
          end
          FN_TERM: begin
            if (tid_hit && exists) begin
              if (k_r == '0) begin
                outcome_nxt = OC_MAIN_TERM;
              end else begin
                outcome_nxt         = OC_OK;
                ring_ctrl.wr.status = ST_UNUSED;
                rm_nxt              = 1'b1;
                if (k_is_run) begin
                  sw_nxt = 1'b1;
                end
              end
            end
          end
          FN_BLOCK: begin
            if (tid_hit && exists) begin
              if (k_r == '0) begin
                outcome_nxt = OC_MAIN_BLOCK;
              end else begin
                outcome_nxt         = OC_OK;
                ring_ctrl.wr.hold   = 1'b1;
                ring_ctrl.wr.status = ST_BLOCKED;
                if (head.status == ST_READY) begin
                  rm_nxt = 1'b1;
                end else if (k_is_run) begin
                  sw_nxt = 1'b1;
                end
              end
            end
          end
          FN_RESUME: begin
            if (tid_hit && exists) begin
              outcome_nxt       = OC_OK;
              ring_ctrl.wr.hold = 1'b0;
              if ((head.status == ST_BLOCKED) && (head.wake <= total_r)) begin
                ring_ctrl.wr.status = ST_READY;
                q_ctrl.enq          = 1'b1;
              end
            end
          end
          FN_SLEEP: begin
            if (k_is_run && (outcome_r == OC_OK)) begin
              ring_ctrl.wr.wake   = total_r + CNT_W'(slen_r) + CNT_W'(1);
              ring_ctrl.wr.status = ST_BLOCKED;
            end
          end
          FN_QUERY: begin
            if (tid_hit && exists) begin
              outcome_nxt = OC_OK;
              answer_nxt  = head.quanta;
            end
          end
          default: begin
          end
        endcase
        if (k_last) begin
          k_nxt      = '0;
          rm_len_nxt = q_len;
          if (rm_nxt) begin
            state_nxt = S_RMV;
          end else if (sw_nxt) begin
            state_nxt = S_WAKE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          k_nxt = k_r + TW'(1);
        end
      end

      // Rotate the queue once through, dropping the removed thread.
      S_RMV: begin
        if (LW'(k_r) < rm_len_r) begin
          q_ctrl.deq = 1'b1;
          q_ctrl.enq = (q_head != tid_r[TW-1:0]);
          q_ctrl.val = ID_W'(q_head);
        end
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = sw_r ? S_WAKE : S_DONE;
        end else begin
          k_nxt = k_r + TW'(1);
        end
      end

      // Wake expired sleepers in thread order and retire the running thread.
      S_WAKE: begin
        ring_ctrl.shift = 1'b1;
        if ((k_r != '0) && (head.status == ST_BLOCKED) && (head.wake != '0) &&
            (head.wake <= upcoming)) begin
          ring_ctrl.wr.wake = '0;
          if (!head.hold) begin
            ring_ctrl.wr.status = ST_READY;
            q_ctrl.enq          = 1'b1;
          end
        end
        if (k_is_run && (head.status == ST_RUNNING)) begin
          ring_ctrl.wr.status = ST_READY;
          cur_req_nxt         = 1'b1;
        end
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_REQ;
        end else begin
          k_nxt = k_r + TW'(1);
        end
      end

      // Requeue the previous running thread behind the woken ones.
      S_REQ: begin
        q_ctrl.enq = cur_req_r;
        q_ctrl.val = ID_W'(running_r);
        state_nxt  = S_POP;
      end

      // Take the queue head, or keep the current thread when the queue is empty.
      S_POP: begin
        if (q_len != '0) begin
          q_ctrl.deq = 1'b1;
          nxt_id_nxt = q_head;
        end else begin
          nxt_id_nxt = running_r;
        end
        state_nxt = S_RUN;
      end

      // Mark the chosen thread running and count its quantum.
      S_RUN: begin
        ring_ctrl.shift = 1'b1;
        if (k_r == nxt_id_r) begin
          ring_ctrl.wr.status = ST_RUNNING;
          ring_ctrl.wr.quanta = head.quanta + CNT_W'(1);
        end
        if (k_last) begin
          k_nxt       = '0;
          running_nxt = nxt_id_r;
          total_nxt   = total_r + CNT_W'(1);
          state_nxt   = S_DONE;
        end else begin
          k_nxt = k_r + TW'(1);
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      sw_r      <= 1'b0;
      rm_r      <= 1'b0;
      found_r   <= 1'b0;
      cur_req_r <= 1'b0;
      running_r <= '0;
      total_r   <= CNT_W'(1);
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      sw_r      <= sw_nxt;
      rm_r      <= rm_nxt;
      found_r   <= found_nxt;
      cur_req_r <= cur_req_nxt;
      running_r <= running_nxt;
      total_r   <= total_nxt;
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    tid_r     <= tid_nxt;
    slen_r    <= slen_nxt;
    outcome_r <= outcome_nxt;
    answer_r  <= answer_nxt;
    nxt_id_r  <= nxt_id_nxt;
    rm_len_r  <= rm_len_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_DONE);
  assign out_outcome     = outcome_r;
  assign out_answer      = answer_r;
  assign out_running_now = ID_W'(running_r);
  assign out_total_now   = total_r;
  assign out_switched    = sw_r;

  // Checks on the sequencer and the queue.
  `RRTS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than a cycle")
  `RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "accepted item not busy")
  `RRTS_ASSERT_NOW(a_queue_cap, 1'b1, q_len <= LW'(MAX_THREADS), "ready queue over capacity")

endmodule
